// File: rtl/v3au_pkg.sv
`default_nettype none

package v3au_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [3:0] ACT_ADD   = 4'd0;
  localparam logic [3:0] ACT_SUB   = 4'd1;
  localparam logic [3:0] ACT_MUL   = 4'd2;
  localparam logic [3:0] ACT_DIV   = 4'd3;
  localparam logic [3:0] ACT_CROSS = 4'd4;
  localparam logic [3:0] ACT_DOT   = 4'd5;
  localparam logic [3:0] ACT_LEN   = 4'd6;
  localparam logic [3:0] ACT_LENSQ = 4'd7;
  localparam logic [3:0] ACT_NORM  = 4'd8;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_CROSS,
    OP_DOT,
    OP_LEN,
    OP_LENSQ,
    OP_NORM,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_MUL2,
    BS_SUM,
    BS_SQRT,
    BS_DIV,
    BS_OUT
  } back_state_e;

  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] ax;
    logic signed [DataW-1:0] ay;
    logic signed [DataW-1:0] az;
    logic signed [DataW-1:0] bx;
    logic signed [DataW-1:0] by;
    logic signed [DataW-1:0] bz;
  } item_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

`default_nettype wire

// File: rtl/v3au_front.sv
`default_nettype none

module v3au_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [3:0]         action_i,
  input  wire logic signed [31:0] ax_i,
  input  wire logic signed [31:0] ay_i,
  input  wire logic signed [31:0] az_i,
  input  wire logic signed [31:0] bx_i,
  input  wire logic signed [31:0] by_i,
  input  wire logic signed [31:0] bz_i,
  output v3au_pkg::item_t         item_o,
  output logic                    item_valid_o,
  input  wire logic               item_pop_i
);
  import v3au_pkg::*;

  item_t      entry_q [2];
  item_t      entry_d;
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  op_e        op;

  always_comb begin
    case (action_i)
      ACT_ADD:   op = OP_ADD;
      ACT_SUB:   op = OP_SUB;
      ACT_MUL:   op = OP_MUL;
      ACT_DIV:   op = OP_DIV;
      ACT_CROSS: op = OP_CROSS;
      ACT_DOT:   op = OP_DOT;
      ACT_LEN:   op = OP_LEN;
      ACT_LENSQ: op = OP_LENSQ;
      ACT_NORM:  op = OP_NORM;
      default:   op = OP_NONE;
    endcase
  end

  assign entry_d      = '{op: op, ax: ax_i, ay: ay_i, az: az_i, bx: bx_i, by: by_i, bz: bz_i};
  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (item_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, item_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= entry_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/v3au_div_lane.sv
`default_nettype none

module v3au_div_lane #(
  parameter int unsigned NW = 49
) (
  input  wire logic              clk_i,
  input  wire v3au_pkg::div_ctl_t ctl_i,
  input  wire logic [NW-1:0]     num_i,
  input  wire logic [32:0]       den_i,
  output logic [NW-1:0]          quot_o
);
  import v3au_pkg::*;

  logic [NW-1:0] num_q;
  logic [32:0]   rem_q;
  logic [32:0]   den_q;
  logic [33:0]   trial;
  logic [33:0]   diff;
  logic          take;

  assign trial  = {rem_q, num_q[NW-1]};
  assign diff   = trial - {1'b0, den_q};
  assign take   = (trial >= {1'b0, den_q});
  assign quot_o = num_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (ctl_i.step) begin
      num_q <= {num_q[NW-2:0], take};
      rem_q <= take ? diff[32:0] : trial[32:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/v3au_back.sv
`default_nettype none

module v3au_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire v3au_pkg::item_t    item_i,
  input  wire logic               item_valid_i,
  output logic                    item_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      rx_o,
  output logic signed [31:0]      ry_o,
  output logic signed [31:0]      rz_o,
  output logic signed [31:0]      scalar_out_o,
  output logic                    overflow_o,
  output logic                    div_zero_o
);
  import v3au_pkg::*;

  localparam int unsigned NW       = 33 + FRAC_BITS;
  localparam int unsigned CW       = $clog2(NW + 1);
  localparam int unsigned SW       = 66;
  localparam int unsigned SQ_STEPS = 32;
  localparam int          NX [3]   = '{1, 2, 0};
  localparam int          PV [3]   = '{2, 0, 1};
  localparam logic signed [SW-1:0] MAXV = 66'sd2147483647;
  localparam logic signed [SW-1:0] MINV = -66'sd2147483648;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic [NW-1:0] Q_MAX     = NW'(64'h7fff_ffff);
  localparam logic [NW-1:0] Q_MIN_MAG = NW'(64'h8000_0000);

  function automatic logic [32:0] sat32(input logic signed [SW-1:0] v);
    if (v > MAXV) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (v < MINV) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [32:0] sat_round(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = (v + HALF) >>> FRAC_BITS;
    return sat32(t);
  endfunction

  back_state_e state_q, state_d;
  op_e         op_q;
  logic signed [31:0] a_q [3];
  logic signed [31:0] b_q [3];
  logic signed [63:0] pa_q [3];
  logic signed [63:0] pb_q [3];
  logic signed [31:0] res_q [3];
  logic signed [31:0] sc_q;
  logic               ovf_q;
  logic               dz_q;
  logic [CW-1:0]      cnt_q;
  logic [63:0]        sq_s_q, sq_r_q, sq_bit_q;
  logic               out_valid_q;
  logic signed [31:0] rx_q, ry_q, rz_q, sc_out_q;
  logic               ovf_out_q, dz_out_q;

  logic signed [31:0] ml [3];
  logic signed [31:0] mr [3];
  logic signed [63:0] prod [3];
  logic [32:0]        add_v [3];
  logic [32:0]        sub_v [3];
  logic [32:0]        mc_v [3];
  logic [31:0]        a_mag [3];
  logic [31:0]        b_mag [3];
  logic signed [SW-1:0] sum3;
  logic [32:0]        sum_v;
  logic [63:0]        sq_trial;
  logic [32:0]        len;
  logic [32:0]        len_v;
  logic [32:0]        den_sel [3];
  logic [NW-1:0]      num_sel [3];
  logic [NW-1:0]      quot [3];
  logic [31:0]        dv_val [3];
  logic [2:0]         dv_ovf;
  logic [2:0]         dv_dz;
  logic               neg;
  logic               sq_done;
  logic               dv_done;
  logic               out_load;
  div_ctl_t           div_ctl;

  assign sq_done = (cnt_q == CW'(SQ_STEPS));
  assign dv_done = (cnt_q == CW'(NW));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (op_q == OP_CROSS && state_q == BS_MUL2) begin
        ml[i] = a_q[PV[i]];
        mr[i] = b_q[NX[i]];
      end else if (op_q == OP_CROSS) begin
        ml[i] = a_q[NX[i]];
        mr[i] = b_q[PV[i]];
      end else if (op_q == OP_LEN || op_q == OP_LENSQ || op_q == OP_NORM) begin
        ml[i] = a_q[i];
        mr[i] = a_q[i];
      end else begin
        ml[i] = a_q[i];
        mr[i] = b_q[i];
      end
      prod[i]  = 64'(ml[i]) * 64'(mr[i]);
      add_v[i] = sat32(SW'(a_q[i]) + SW'(b_q[i]));
      sub_v[i] = sat32(SW'(a_q[i]) - SW'(b_q[i]));
      mc_v[i]  = sat_round(SW'(pa_q[i]) - SW'(pb_q[i]));
      a_mag[i] = a_q[i][31] ? 32'(-a_q[i]) : 32'(a_q[i]);
      b_mag[i] = b_q[i][31] ? 32'(-b_q[i]) : 32'(b_q[i]);
    end
  end

  assign sum3     = SW'(pa_q[0]) + SW'(pa_q[1]) + SW'(pa_q[2]);
  assign sum_v    = sat_round(sum3);
  assign sq_trial = sq_r_q + sq_bit_q;
  assign len      = {1'b0, sq_r_q[31:0]} + {32'd0, (sq_s_q > sq_r_q)};
  assign len_v    = sat32(SW'(len));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      den_sel[i] = (state_q == BS_SUM) ? {1'b0, b_mag[i]} : len;
      num_sel[i] = (NW'(a_mag[i]) << FRAC_BITS) + NW'(den_sel[i][32:1]);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    v3au_div_lane #(.NW(NW)) u_lane (
      .clk_i  (clk_i),
      .ctl_i  (div_ctl),
      .num_i  (num_sel[g]),
      .den_i  (den_sel[g]),
      .quot_o (quot[g])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg       = (op_q == OP_DIV) ? (a_q[i][31] ^ b_q[i][31]) : a_q[i][31];
      dv_ovf[i] = 1'b0;
      dv_dz[i]  = 1'b0;
      if (op_q == OP_DIV && b_q[i] == 32'sd0) begin
        dv_dz[i] = 1'b1;
        if (a_q[i] > 32'sd0) begin
          dv_val[i] = 32'h7fff_ffff;
        end else if (a_q[i] < 32'sd0) begin
          dv_val[i] = 32'h8000_0000;
        end else begin
          dv_val[i] = 32'd0;
        end
      end else if (neg) begin
        if (quot[i] > Q_MIN_MAG) begin
          dv_ovf[i] = 1'b1;
          dv_val[i] = 32'h8000_0000;
        end else begin
          dv_val[i] = 32'd0 - quot[i][31:0];
        end
      end else if (quot[i] > Q_MAX) begin
        dv_ovf[i] = 1'b1;
        dv_val[i] = 32'h7fff_ffff;
      end else begin
        dv_val[i] = quot[i][31:0];
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    item_pop_o   = 1'b0;
    div_ctl      = '0;
    out_load     = 1'b0;
    case (state_q)
      BS_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          state_d    = BS_MUL;
        end
      end
      BS_MUL: begin
        state_d = (op_q == OP_CROSS) ? BS_MUL2 : BS_SUM;
      end
      BS_MUL2: begin
        state_d = BS_SUM;
      end
      BS_SUM: begin
        case (op_q)
          OP_LEN: begin
            state_d = BS_SQRT;
          end
          OP_NORM: begin
            state_d = (sum3 == '0) ? BS_OUT : BS_SQRT;
          end
          OP_DIV: begin
            div_ctl.load = 1'b1;
            state_d      = BS_DIV;
          end
          default: begin
            state_d = BS_OUT;
          end
        endcase
      end
      BS_SQRT: begin
        if (sq_done) begin
          if (op_q == OP_NORM) begin
            div_ctl.load = 1'b1;
            state_d      = BS_DIV;
          end else begin
            state_d = BS_OUT;
          end
        end
      end
      BS_DIV: begin
        if (dv_done) begin
          state_d = BS_OUT;
        end else begin
          div_ctl.step = 1'b1;
        end
      end
      BS_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BS_IDLE: begin
        if (item_pop_o) begin
          op_q   <= item_i.op;
          a_q[0] <= item_i.ax;
          a_q[1] <= item_i.ay;
          a_q[2] <= item_i.az;
          b_q[0] <= item_i.bx;
          b_q[1] <= item_i.by;
          b_q[2] <= item_i.bz;
          ovf_q  <= 1'b0;
          dz_q   <= 1'b0;
          sc_q   <= '0;
          for (int i = 0; i < 3; i++) begin
            res_q[i] <= '0;
          end
        end
      end
      BS_MUL: begin
        for (int i = 0; i < 3; i++) begin
          pa_q[i] <= prod[i];
          pb_q[i] <= '0;
        end
      end
      BS_MUL2: begin
        for (int i = 0; i < 3; i++) begin
          pb_q[i] <= prod[i];
        end
      end
      BS_SUM: begin
        cnt_q    <= '0;
        sq_s_q   <= sum3[63:0];
        sq_r_q   <= '0;
        sq_bit_q <= 64'h4000_0000_0000_0000;
        case (op_q)
          OP_ADD: begin
            for (int i = 0; i < 3; i++) begin
              res_q[i] <= add_v[i][31:0];
            end
            ovf_q <= add_v[0][32] | add_v[1][32] | add_v[2][32];
          end
          OP_SUB: begin
            for (int i = 0; i < 3; i++) begin
              res_q[i] <= sub_v[i][31:0];
            end
            ovf_q <= sub_v[0][32] | sub_v[1][32] | sub_v[2][32];
          end
          OP_MUL, OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
              res_q[i] <= mc_v[i][31:0];
            end
            ovf_q <= mc_v[0][32] | mc_v[1][32] | mc_v[2][32];
          end
          OP_DOT, OP_LENSQ: begin
            sc_q  <= sum_v[31:0];
            ovf_q <= sum_v[32];
          end
          default: begin
          end
        endcase
      end
      BS_SQRT: begin
        if (!sq_done) begin
          cnt_q    <= cnt_q + CW'(1);
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_s_q >= sq_trial) begin
            sq_s_q <= sq_s_q - sq_trial;
            sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
          end else begin
            sq_r_q <= sq_r_q >> 1;
          end
        end else begin
          cnt_q <= '0;
          sc_q  <= len_v[31:0];
          ovf_q <= len_v[32];
        end
      end
      BS_DIV: begin
        if (!dv_done) begin
          cnt_q <= cnt_q + CW'(1);
        end else begin
          for (int i = 0; i < 3; i++) begin
            res_q[i] <= dv_val[i];
          end
          ovf_q <= ovf_q | (|dv_ovf);
          dz_q  <= |dv_dz;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      rx_q      <= res_q[0];
      ry_q      <= res_q[1];
      rz_q      <= res_q[2];
      sc_out_q  <= sc_q;
      ovf_out_q <= ovf_q;
      dz_out_q  <= dz_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rx_o         = rx_q;
  assign ry_o         = ry_q;
  assign rz_o         = rz_q;
  assign scalar_out_o = sc_out_q;
  assign overflow_o   = ovf_out_q;
  assign div_zero_o   = dz_out_q;

endmodule

`default_nettype wire

// File: rtl/vector3_arithmetic_unit.sv
// Channel | Direction | Handshake              | Payload
// input   | in        | in_valid_i, in_stall_o | action_i, ax_i..az_i, bx_i..bz_i
// output  | out       | out_valid_o, out_stall_i | rx_o, ry_o, rz_o, scalar_out_o, flags
//
// A two-entry queue takes an item every cycle until full; the back end runs one item at a time.
// Add, sub, mul, dot and squared length pass through the MUL, SUM and OUT states; cross also
// passes MUL2, reusing the shared multipliers. Length adds the 32-step square root, divide the
// bit-serial dividers; normalize runs the root and then the divide unless the vector is zero.
// Reset is asynchronous and clears the queue, the sequencer and the output valid.
// A stalled output holds its item while the queue keeps accepting new items until it is full.
`default_nettype none

module vector3_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [3:0]         action_i,
  input  wire logic signed [31:0] ax_i,
  input  wire logic signed [31:0] ay_i,
  input  wire logic signed [31:0] az_i,
  input  wire logic signed [31:0] bx_i,
  input  wire logic signed [31:0] by_i,
  input  wire logic signed [31:0] bz_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      rx_o,
  output logic signed [31:0]      ry_o,
  output logic signed [31:0]      rz_o,
  output logic signed [31:0]      scalar_out_o,
  output logic                    overflow_o,
  output logic                    div_zero_o
);
  import v3au_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_pop;

  v3au_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .ax_i         (ax_i),
    .ay_i         (ay_i),
    .az_i         (az_i),
    .bx_i         (bx_i),
    .by_i         (by_i),
    .bz_i         (bz_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  v3au_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rx_o         (rx_o),
    .ry_o         (ry_o),
    .rz_o         (rz_o),
    .scalar_out_o (scalar_out_o),
    .overflow_o   (overflow_o),
    .div_zero_o   (div_zero_o)
  );

endmodule

`default_nettype wire

// File: rtl/v3au_checker.sv
`default_nettype none

module v3au_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] rx_o,
  input wire logic signed [31:0] ry_o,
  input wire logic signed [31:0] rz_o,
  input wire logic signed [31:0] scalar_out_o,
  input wire logic               overflow_o,
  input wire logic               div_zero_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(rx_o) && $stable(ry_o) && $stable(rz_o)
      && $stable(scalar_out_o) && $stable(overflow_o) && $stable(div_zero_o))
    else $error("Output item changed while stalled.");

  a_dz_no_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_zero_o |-> scalar_out_o == 32'sd0)
    else $error("Divide item carries a scalar result.");

  a_neg_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scalar_out_o[31] |-> rx_o == 32'sd0 && ry_o == 32'sd0 && rz_o == 32'sd0)
    else $error("Negative scalar result with a nonzero vector.");

endmodule

bind vector3_arithmetic_unit v3au_checker u_v3au_checker (.*);

`default_nettype wire

// File: test/tb_vector3_arithmetic_unit.sv
`default_nettype none

module tb_vector3_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import v3au_pkg::*;

  localparam int unsigned Frac = 16;
  localparam longint Max32 = 64'sd2147483647;
  localparam longint Min32 = -64'sd2147483648;

  typedef struct {
    logic [3:0] act;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
  } vec_item_t;

  typedef struct {
    logic signed [31:0] r [3];
    logic signed [31:0] sc;
    logic ovf;
    logic dz;
  } vec_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [3:0] action_i = '0;
  logic signed [31:0] ax_i = '0, ay_i = '0, az_i = '0, bx_i = '0, by_i = '0, bz_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] rx_o, ry_o, rz_o, scalar_out_o;
  logic overflow_o, div_zero_o;

  vector3_arithmetic_unit #(.FRAC_BITS(Frac)) u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vec_res_t pending_q [$];
  int n_err = 0;
  int n_items = 0;
  int n_res = 0;
  int stall_left = 0;
  int op_seen [16];

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", n_res, what, got, want);
    n_err++;
  endtask

  function automatic logic signed [31:0] clip(input longint v, inout logic ovf);
    if (v > Max32) begin
      ovf = 1'b1;
      return 32'(Max32);
    end
    if (v < Min32) begin
      ovf = 1'b1;
      return 32'(Min32);
    end
    return 32'(v);
  endfunction

  // Exact sum of products rounded to Frac bits, ties upward (floor of sum + half).
  function automatic longint round_prod(input logic signed [127:0] s);
    logic signed [127:0] t;
    t = (s + (128'sd1 <<< (Frac - 1))) >>> Frac;
    if (t > 128'sd4611686018427387904) return 64'sh4000_0000_0000_0000;
    if (t < -128'sd4611686018427387904) return -64'sh4000_0000_0000_0000;
    return longint'(t);
  endfunction

  function automatic longint div_near(input longint num, input longint den);
    logic [63:0] un, ud, q;
    bit neg;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (un + ud / 2) / ud;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [63:0] root_near(input logic [63:0] s);
    logic [63:0] r, lo, hi, mid;
    lo = 0;
    hi = 64'd4294967296;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= s) lo = mid;
      else hi = mid - 1;
    end
    r = lo;
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic vec_res_t vec_predict(input vec_item_t it);
    vec_res_t res;
    longint a [3], b [3], v, len;
    logic [63:0] sq;
    logic ovf;
    int j, k;
    ovf = 1'b0;
    res.dz = 1'b0;
    res.sc = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = it.a[i];
      b[i] = it.b[i];
      res.r[i] = '0;
    end
    sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    case (it.act)
      ACT_ADD: for (int i = 0; i < 3; i++) res.r[i] = clip(a[i] + b[i], ovf);
      ACT_SUB: for (int i = 0; i < 3; i++) res.r[i] = clip(a[i] - b[i], ovf);
      ACT_MUL: for (int i = 0; i < 3; i++) res.r[i] = clip(round_prod(a[i] * b[i]), ovf);
      ACT_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (b[i] == 0) begin
            res.dz = 1'b1;
            res.r[i] = a[i] > 0 ? 32'sh7fff_ffff : (a[i] < 0 ? 32'sh8000_0000 : 32'sh0);
          end else begin
            res.r[i] = clip(div_near(a[i] * (64'sd1 <<< Frac), b[i]), ovf);
          end
        end
      end
      ACT_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          res.r[i] = clip(round_prod(128'(a[j] * b[k]) - 128'(a[k] * b[j])), ovf);
        end
      end
      ACT_DOT: res.sc = clip(round_prod(128'(a[0] * b[0]) + 128'(a[1] * b[1])
                                        + 128'(a[2] * b[2])), ovf);
      ACT_LEN: res.sc = clip(longint'(root_near(sq)), ovf);
      ACT_LENSQ: begin
        v = longint'((sq + (64'd1 << (Frac - 1))) >> Frac);
        res.sc = clip(v, ovf);
      end
      ACT_NORM: begin
        if (sq != 0) begin
          len = longint'(root_near(sq));
          for (int i = 0; i < 3; i++) begin
            res.r[i] = clip(div_near(a[i] * (64'sd1 <<< Frac), len), ovf);
          end
          res.sc = clip(len, ovf);
        end
      end
      default: ;
    endcase
    res.ovf = ovf;
    return res;
  endfunction

  task automatic send(input vec_item_t it, input vec_res_t want);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pending_q.push_back(want);
    op_seen[it.act]++;
    in_valid_i <= 1'b1;
    action_i <= it.act;
    ax_i <= it.a[0];
    ay_i <= it.a[1];
    az_i <= it.a[2];
    bx_i <= it.b[0];
    by_i <= it.b[1];
    bz_i <= it.b[2];
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
  endtask

  function automatic logic signed [31:0] rand_comp(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      default: return 0;
    endcase
  endfunction

  // After each taken result the receiver holds off for a drawn number of cycles.
  always @(posedge clk_i) begin
    int wait_n;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        wait_n = $urandom_range(0, 5);
        stall_left <= wait_n;
        out_stall_i <= (wait_n != 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= 0;
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    vec_res_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("result with no item outstanding");
        n_err++;
      end else begin
        w = pending_q.pop_front();
        if (rx_o !== w.r[0]) report("rx", longint'(rx_o), longint'(w.r[0]));
        if (ry_o !== w.r[1]) report("ry", longint'(ry_o), longint'(w.r[1]));
        if (rz_o !== w.r[2]) report("rz", longint'(rz_o), longint'(w.r[2]));
        if (scalar_out_o !== w.sc) begin
          report("scalar_out", longint'(scalar_out_o), longint'(w.sc));
        end
        if (overflow_o !== w.ovf) report("overflow", longint'(overflow_o), longint'(w.ovf));
        if (div_zero_o !== w.dz) report("div_zero", longint'(div_zero_o), longint'(w.dz));
      end
      n_res++;
    end
  end

  initial begin
    #50ms;
    $display("tb_vector3_arithmetic_unit: errors");
    $finish;
  end

  initial begin
    vec_item_t dir [$];
    vec_item_t it;
    vec_res_t hand [$];
    logic signed [31:0] mx, mn, one;
    int mode;
    int n_unk;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    one = 32'sh0001_0000;
    n_unk = 0;
    it.act = ACT_ADD; it.a = '{mx, mn, 0}; it.b = '{mx, mn, 0}; dir.push_back(it);
    it.act = ACT_SUB; it.a = '{mn, mx, -1}; it.b = '{1, -1, 1}; dir.push_back(it);
    it.act = ACT_MUL; it.a = '{mx, mn, mn}; it.b = '{mx, mn, mx}; dir.push_back(it);
    it.act = ACT_MUL; it.a = '{one, 32'sh8000, -1}; it.b = '{one, 1, 32'sh8000}; dir.push_back(it);
    it.act = ACT_DIV; it.a = '{5, -5, 0}; it.b = '{0, 0, 0}; dir.push_back(it);
    it.act = ACT_DIV; it.a = '{mx, mn, 3}; it.b = '{1, mx, -2}; dir.push_back(it);
    it.act = ACT_DIV; it.a = '{mn, 1, -1}; it.b = '{-1, 2, 2}; dir.push_back(it);
    it.act = ACT_CROSS; it.a = '{mx, mn, mx}; it.b = '{mn, mx, mn}; dir.push_back(it);
    it.act = ACT_CROSS; it.a = '{one, 0, 0}; it.b = '{0, one, 0}; dir.push_back(it);
    it.act = ACT_DOT; it.a = '{mn, mn, mn}; it.b = '{mn, mn, mn}; dir.push_back(it);
    it.act = ACT_DOT; it.a = '{mx, mn, 1}; it.b = '{mn, mx, 1}; dir.push_back(it);
    it.act = ACT_LEN; it.a = '{mn, mn, mn}; it.b = '{mx, 0, 0}; dir.push_back(it);
    it.act = ACT_LEN; it.a = '{3 * one, 4 * one, 0}; it.b = '{0, 0, 0}; dir.push_back(it);
    it.act = ACT_LENSQ; it.a = '{mn, mx, mn}; it.b = '{0, 0, 0}; dir.push_back(it);
    it.act = ACT_LENSQ; it.a = '{1, 0, 0}; it.b = '{0, 0, 0}; dir.push_back(it);
    it.act = ACT_NORM; it.a = '{0, 0, 0}; it.b = '{mx, mx, mx}; dir.push_back(it);
    it.act = ACT_NORM; it.a = '{mn, mx, 1}; it.b = '{0, 0, 0}; dir.push_back(it);
    it.act = ACT_NORM; it.a = '{1, 0, 0}; it.b = '{0, 0, 0}; dir.push_back(it);
    it.act = 4'd15; it.a = '{mx, mn, 1}; it.b = '{mn, mx, 1}; dir.push_back(it);
    it.act = 4'd9; it.a = '{-1, -1, -1}; it.b = '{-1, -1, -1}; dir.push_back(it);
    // Values read straight off the arithmetic for the first rows.
    hand.push_back('{r: '{mx, mn, 0}, sc: 0, ovf: 1, dz: 0});
    hand.push_back('{r: '{mn, mx, -2}, sc: 0, ovf: 1, dz: 0});
    hand.push_back('{r: '{mx, mx, mn}, sc: 0, ovf: 1, dz: 0});
    hand.push_back('{r: '{one, 1, 0}, sc: 0, ovf: 0, dz: 0});
    hand.push_back('{r: '{mx, mn, 0}, sc: 0, ovf: 0, dz: 1});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir[i]) begin
      if (i < hand.size()) begin
        send(dir[i], hand[i]);
      end else begin
        send(dir[i], vec_predict(dir[i]));
      end
    end
    for (int n = 0; n < 400; n++) begin
      if (n == 200) begin
        in_valid_i <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      it.act = $urandom_range(0, 19) == 0 ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      for (int c = 0; c < 3; c++) begin
        it.a[c] = rand_comp(mode == 3 ? $urandom_range(0, 3) : mode);
        it.b[c] = rand_comp(mode == 3 ? $urandom_range(0, 3) : mode);
      end
      send(it, vec_predict(it));
    end
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    for (int c = 9; c < 16; c++) n_unk += op_seen[c];
    $display("Sent %0d items and checked %0d results across all nine operations.",
             n_items, n_res);
    $display("Div items %0d, normalize items %0d, unknown-action items %0d.",
             op_seen[ACT_DIV], op_seen[ACT_NORM], n_unk);
    if (n_err == 0) begin
      $display("tb_vector3_arithmetic_unit: clean");
    end else begin
      $display("tb_vector3_arithmetic_unit: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
